// ----- rtl/core/rskc_pkg.sv -----
package rskc_pkg;

    // Sample width and the widths that follow from it.
    localparam int SAMPLE_BITS = 16;
    localparam int SQ_SH  = 2 * (SAMPLE_BITS - 1) - 30;
    localparam int SQ_RSH = (SQ_SH > 0) ? SQ_SH : 0;
    localparam int SQ_LSH = (SQ_SH < 0) ? -SQ_SH : 0;

    localparam int MUL_A_W = (SAMPLE_BITS + 18 > 34) ? SAMPLE_BITS + 18 : 34;
    localparam int MUL_B_W = (SAMPLE_BITS + 1 > 24) ? SAMPLE_BITS + 1 : 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam longint SMP_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SMP_MIN = -SMP_MAX - 1;

    // Soft knee divider sizes.
    localparam int DIV_NUM_W = 25;
    localparam int DIV_DEN_W = 13;
    localparam int DIV_Q_W   = 13;

    // Fixed-point scale factors.
    localparam int LOG_BIAS  = 30 * 65536;
    localparam int LVL_SCALE = 197283;
    localparam int EXP_SCALE = 10885;

    // Configuration register indexes.
    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_SLOPE     = 3'd1;
    localparam logic [2:0] CFG_KNEE      = 3'd2;
    localparam logic [2:0] CFG_ATTACK    = 3'd3;
    localparam logic [2:0] CFG_RELEASE   = 3'd4;
    localparam logic [2:0] CFG_RMS       = 3'd5;
    localparam logic [2:0] CFG_MAKEUP    = 3'd6;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_sample;
        logic [16:0]                   gain_now;
        logic                          last_out;
    } t_out_item;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQ, ST_ENV0, ST_ENV1, ST_PREP, ST_NORM, ST_LOG, ST_LVL,
        ST_RED, ST_X2, ST_SOFT, ST_DIV, ST_EXPM, ST_EXP, ST_GAIN0, ST_GAIN1,
        ST_OUT0, ST_OUT1, ST_DONE
    } t_state;

    function automatic logic [16:0] log2_lut(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd5732;
            5'd2:    v = 17'd11136;
            5'd3:    v = 17'd16248;
            5'd4:    v = 17'd21098;
            5'd5:    v = 17'd25711;
            5'd6:    v = 17'd30109;
            5'd7:    v = 17'd34312;
            5'd8:    v = 17'd38336;
            5'd9:    v = 17'd42196;
            5'd10:   v = 17'd45904;
            5'd11:   v = 17'd49472;
            5'd12:   v = 17'd52911;
            5'd13:   v = 17'd56229;
            5'd14:   v = 17'd59434;
            5'd15:   v = 17'd62534;
            5'd16:   v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp2_lut(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/rms_soft_knee_compressor_unit.sv -----
// Channel | Direction | Handshake              | Payload
// in      | request   | i_in_valid, o_in_stall | i_in  (sample, last_sample)
// out     | result    | o_out_valid, i_out_stall | o_out (out_sample, gain_now, last_out)
// cfg     | write     | i_cfg_valid, o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each request runs to completion before the next is accepted. Inside the soft knee the
// sequence adds two multiplies and a divide to the hard knee or no-reduction path. The
// request rate is set by the single shared multiplier and the five-step leading-one search.
// Reset (synchronous, active low) restores the register defaults, a zero envelope and
// unity gain. The input is stalled from acceptance until the result is written to the
// output register, which holds a stalled result while the next request is processed.
module rms_soft_knee_compressor_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rskc_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rskc_pkg::t_out_item  o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    localparam int SB = rskc_pkg::SAMPLE_BITS;
    localparam int PW = rskc_pkg::MUL_P_W;

    rskc_pkg::t_state r_state, n_state;

    // Configuration registers.
    logic signed [15:0] r_thr;
    logic [15:0]        r_slope;
    logic [12:0]        r_knee;
    logic [15:0]        r_att;
    logic [15:0]        r_rel;
    logic [15:0]        r_rmsc;
    logic [15:0]        r_mkup;

    // Persistent state and per-request working registers.
    logic [31:0]          r_env;
    logic [16:0]          r_g;
    logic signed [SB-1:0] r_s;
    logic                 r_last;
    logic [30:0]          r_sq;
    logic signed [PW-1:0] r_acc;
    logic [31:0]          r_m;
    logic [4:0]           r_e;
    logic [2:0]           r_k;
    logic [20:0]          r_lg;
    logic signed [17:0]   r_lvl;
    logic signed [19:0]   r_red;
    logic [14:0]          r_x2;
    logic [24:0]          r_n;
    logic [16:0]          r_tgt;
    logic [15:0]          r_c;
    logic signed [SB-1:0] r_y;
    logic                 r_ovalid;
    rskc_pkg::t_out_item  r_out;

    logic signed [rskc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [rskc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]                mul_p;
    rskc_pkg::t_div_req                  div_req;
    logic [rskc_pkg::DIV_Q_W-1:0]        div_quot;
    logic                                div_done;

    logic [SB:0]          s_ext;
    logic [SB:0]          abs_s;
    logic [2*SB:0]        sq_full;
    logic signed [PW-1:0] env_sum;
    logic                 norm_zero;
    logic [4:0]           norm_sa;
    logic [16:0]          lg_lo, lg_hi;
    logic signed [22:0]   lvl_arg;
    logic [15:0]          ns;
    logic signed [18:0]   d;
    logic signed [19:0]   d2, w20, x2_full;
    logic                 red_hard, red_soft;
    logic [18:0]          hard_mag;
    logic [3:0]           ex_idx;
    logic [16:0]          ex_a, ex_b, ex_v;
    logic [8:0]           ex_i;
    logic [16:0]          ex_tgt;
    logic [15:0]          gain_c;
    logic signed [PW-1:0] y_full;
    logic                 out_free;

    rskc_mul u_mul (
        .i_a (mul_a),
        .i_b (mul_b),
        .o_p (mul_p)
    );

    rskc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_quot  (div_quot),
        .o_done  (div_done)
    );

    // Operand shaping and the values each step derives from the product.
    always_comb begin
        s_ext    = {r_s[SB-1], r_s};
        abs_s    = s_ext[SB] ? (~s_ext + 1'b1) : s_ext;
        sq_full  = mul_p[2*SB:0];
        env_sum  = r_acc + mul_p;

        // Leading-one search in halving steps of 16, 8, 4, 2 and 1 bits.
        case (r_k)
            3'd0: begin
                norm_zero = (r_m[31:16] == 16'd0);
                norm_sa   = 5'd16;
            end
            3'd1: begin
                norm_zero = (r_m[31:24] == 8'd0);
                norm_sa   = 5'd8;
            end
            3'd2: begin
                norm_zero = (r_m[31:28] == 4'd0);
                norm_sa   = 5'd4;
            end
            3'd3: begin
                norm_zero = (r_m[31:30] == 2'd0);
                norm_sa   = 5'd2;
            end
            default: begin
                norm_zero = !r_m[31];
                norm_sa   = 5'd1;
            end
        endcase

        lg_lo   = rskc_pkg::log2_lut({1'b0, r_m[30:27]});
        lg_hi   = rskc_pkg::log2_lut(5'({1'b0, r_m[30:27]} + 5'd1));
        lvl_arg = $signed({2'b00, r_lg}) - 23'(rskc_pkg::LOG_BIAS);

        // A slope above zero would expand; it is held at zero instead.
        ns       = r_slope[15] ? (16'd0 - r_slope) : 16'd0;
        d        = {r_lvl[17], r_lvl} - {{3{r_thr[15]}}, r_thr};
        d2       = {d, 1'b0};
        w20      = {7'd0, r_knee};
        red_hard = (d2 >= w20);
        red_soft = (d2 > -w20) && (d2 < w20);
        x2_full  = d2 + w20;
        hard_mag = mul_p[33:15];

        ex_idx = r_n[15:12];
        ex_i   = r_n[24:16];
        ex_a   = rskc_pkg::exp2_lut({1'b0, ex_idx});
        ex_b   = rskc_pkg::exp2_lut(5'({1'b0, ex_idx} + 5'd1));
        ex_v   = ex_a - {5'd0, mul_p[23:12]};
        ex_tgt = (ex_i >= 9'd17) ? 17'd0 : (ex_v >> ex_i[4:0]);

        // Attack applies when the gain has to fall, release when it rises.
        gain_c = (r_tgt < r_g) ? r_att : r_rel;

        y_full = (mul_p + (PW'(1) <<< 27)) >>> 28;
    end

    assign out_free = !r_ovalid || !i_out_stall;

    // Sequencer: next state and multiplier operand selection.
    always_comb begin
        n_state = r_state;
        mul_a   = '0;
        mul_b   = '0;
        div_req = '0;
        case (r_state)
            rskc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = rskc_pkg::ST_SQ;
                end
            end
            rskc_pkg::ST_SQ: begin
                mul_a   = rskc_pkg::MUL_A_W'(abs_s);
                mul_b   = rskc_pkg::MUL_B_W'(abs_s);
                n_state = rskc_pkg::ST_ENV0;
            end
            rskc_pkg::ST_ENV0: begin
                mul_a   = rskc_pkg::MUL_A_W'(r_env);
                mul_b   = rskc_pkg::MUL_B_W'(r_rmsc);
                n_state = rskc_pkg::ST_ENV1;
            end
            rskc_pkg::ST_ENV1: begin
                mul_a   = rskc_pkg::MUL_A_W'(r_sq);
                mul_b   = rskc_pkg::MUL_B_W'(17'd65536 - {1'b0, r_rmsc});
                n_state = rskc_pkg::ST_PREP;
            end
            rskc_pkg::ST_PREP: begin
                n_state = rskc_pkg::ST_NORM;
            end
            rskc_pkg::ST_NORM: begin
                if (r_k == 3'd4) begin
                    n_state = rskc_pkg::ST_LOG;
                end
            end
            rskc_pkg::ST_LOG: begin
                mul_a   = rskc_pkg::MUL_A_W'(lg_hi - lg_lo);
                mul_b   = rskc_pkg::MUL_B_W'(r_m[26:11]);
                n_state = rskc_pkg::ST_LVL;
            end
            rskc_pkg::ST_LVL: begin
                mul_a   = rskc_pkg::MUL_A_W'(lvl_arg);
                mul_b   = rskc_pkg::MUL_B_W'(rskc_pkg::LVL_SCALE);
                n_state = rskc_pkg::ST_RED;
            end
            rskc_pkg::ST_RED: begin
                mul_a = rskc_pkg::MUL_A_W'(d);
                mul_b = rskc_pkg::MUL_B_W'(ns);
                if (red_soft) begin
                    n_state = rskc_pkg::ST_X2;
                end else begin
                    n_state = rskc_pkg::ST_EXPM;
                end
            end
            rskc_pkg::ST_X2: begin
                mul_a   = rskc_pkg::MUL_A_W'(r_x2);
                mul_b   = rskc_pkg::MUL_B_W'(r_x2);
                n_state = rskc_pkg::ST_SOFT;
            end
            rskc_pkg::ST_SOFT: begin
                mul_a         = rskc_pkg::MUL_A_W'(r_acc[27:0]);
                mul_b         = rskc_pkg::MUL_B_W'(ns);
                div_req.start = 1'b1;
                div_req.num   = mul_p[42:18];
                div_req.den   = r_knee;
                n_state       = rskc_pkg::ST_DIV;
            end
            rskc_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = rskc_pkg::ST_EXPM;
                end
            end
            rskc_pkg::ST_EXPM: begin
                mul_a   = rskc_pkg::MUL_A_W'(r_red);
                mul_b   = rskc_pkg::MUL_B_W'(rskc_pkg::EXP_SCALE);
                n_state = rskc_pkg::ST_EXP;
            end
            rskc_pkg::ST_EXP: begin
                mul_a   = rskc_pkg::MUL_A_W'(ex_a - ex_b);
                mul_b   = rskc_pkg::MUL_B_W'(r_n[11:0]);
                n_state = rskc_pkg::ST_GAIN0;
            end
            rskc_pkg::ST_GAIN0: begin
                mul_a   = rskc_pkg::MUL_A_W'(r_g);
                mul_b   = rskc_pkg::MUL_B_W'(gain_c);
                n_state = rskc_pkg::ST_GAIN1;
            end
            rskc_pkg::ST_GAIN1: begin
                mul_a   = rskc_pkg::MUL_A_W'(r_tgt);
                mul_b   = rskc_pkg::MUL_B_W'(17'd65536 - {1'b0, r_c});
                n_state = rskc_pkg::ST_OUT0;
            end
            rskc_pkg::ST_OUT0: begin
                mul_a   = rskc_pkg::MUL_A_W'(r_s);
                mul_b   = rskc_pkg::MUL_B_W'(r_g);
                n_state = rskc_pkg::ST_OUT1;
            end
            rskc_pkg::ST_OUT1: begin
                mul_a   = r_acc[rskc_pkg::MUL_A_W-1:0];
                mul_b   = rskc_pkg::MUL_B_W'(r_mkup);
                n_state = rskc_pkg::ST_DONE;
            end
            rskc_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = rskc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rskc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rskc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers; the user must write them only while the block is idle (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= -16'sd6144;
            r_slope <= 16'hA000;
            r_knee  <= 13'd1536;
            r_att   <= 16'd65400;
            r_rel   <= 16'd65522;
            r_rmsc  <= 16'd65400;
            r_mkup  <= 16'd4096;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rskc_pkg::CFG_THRESHOLD: r_thr   <= i_cfg_data;
                rskc_pkg::CFG_SLOPE:     r_slope <= i_cfg_data;
                rskc_pkg::CFG_KNEE:      r_knee  <= i_cfg_data[12:0];
                rskc_pkg::CFG_ATTACK:    r_att   <= i_cfg_data;
                rskc_pkg::CFG_RELEASE:   r_rel   <= i_cfg_data;
                rskc_pkg::CFG_RMS:       r_rmsc  <= i_cfg_data;
                rskc_pkg::CFG_MAKEUP:    r_mkup  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Envelope and smoothed gain carry over from one request to the next.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env <= 32'd0;
            r_g   <= 17'd65536;
        end else begin
            if (r_state == rskc_pkg::ST_ENV1) begin
                r_env <= env_sum[47:16];
            end
            if (r_state == rskc_pkg::ST_GAIN1) begin
                r_g <= env_sum[32:16];
            end
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            rskc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    r_s    <= i_in.sample;
                    r_last <= i_in.last_sample;
                end
            end
            rskc_pkg::ST_SQ: begin
                r_sq <= (31'(sq_full >> rskc_pkg::SQ_RSH)) << rskc_pkg::SQ_LSH;
            end
            rskc_pkg::ST_ENV0: begin
                r_acc <= mul_p;
            end
            rskc_pkg::ST_PREP: begin
                r_m <= r_env + 32'd1;
                r_e <= 5'd31;
                r_k <= 3'd0;
            end
            rskc_pkg::ST_NORM: begin
                if (norm_zero) begin
                    r_m <= r_m << norm_sa;
                    r_e <= r_e - norm_sa;
                end
                r_k <= r_k + 3'd1;
            end
            rskc_pkg::ST_LOG: begin
                r_lg <= {r_e, 16'd0} + {4'd0, lg_lo} + {8'd0, mul_p[28:16]};
            end
            rskc_pkg::ST_LVL: begin
                r_lvl <= 18'(mul_p >>> 24);
            end
            rskc_pkg::ST_RED: begin
                if (red_hard) begin
                    r_red <= -$signed({1'b0, hard_mag});
                end else if (red_soft) begin
                    r_x2 <= x2_full[14:0];
                end else begin
                    r_red <= 20'sd0;
                end
            end
            rskc_pkg::ST_X2: begin
                r_acc <= mul_p;
            end
            rskc_pkg::ST_DIV: begin
                if (div_done) begin
                    r_red <= -$signed({7'd0, div_quot});
                end
            end
            rskc_pkg::ST_EXPM: begin
                r_n <= 25'(-(mul_p >>> 8));
            end
            rskc_pkg::ST_EXP: begin
                r_tgt <= ex_tgt;
            end
            rskc_pkg::ST_GAIN0: begin
                r_acc <= mul_p;
                r_c   <= gain_c;
            end
            rskc_pkg::ST_OUT0: begin
                r_acc <= mul_p;
            end
            rskc_pkg::ST_OUT1: begin
                if (y_full > PW'(rskc_pkg::SMP_MAX)) begin
                    r_y <= SB'(rskc_pkg::SMP_MAX);
                end else if (y_full < PW'(rskc_pkg::SMP_MIN)) begin
                    r_y <= SB'(rskc_pkg::SMP_MIN);
                end else begin
                    r_y <= SB'(y_full);
                end
            end
            default: ;
        endcase
    end

    // Output register: holds a finished result until the far side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == rskc_pkg::ST_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rskc_pkg::ST_DONE && out_free) begin
            r_out.out_sample <= r_y;
            r_out.gain_now   <= r_g;
            r_out.last_out   <= r_last;
        end
    end

    assign o_in_stall  = (r_state != rskc_pkg::ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- rtl/core/rskc_mul.sv -----
// Shared signed multiplier used by every multiply step of the sequencer.
module rskc_mul (
    input  logic signed [rskc_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [rskc_pkg::MUL_B_W-1:0] i_b,
    output logic signed [rskc_pkg::MUL_P_W-1:0] o_p
);

    always_comb begin
        o_p = rskc_pkg::MUL_P_W'(i_a) * rskc_pkg::MUL_P_W'(i_b);
    end

endmodule

// ----- rtl/core/rskc_div.sv -----
// Restoring divider, one quotient bit per cycle. The upper numerator bits are
// known to stay below the divisor, so only the low bits are iterated.
module rskc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rskc_pkg::t_div_req            i_req,
    output logic [rskc_pkg::DIV_Q_W-1:0]  o_quot,
    output logic                          o_done
);

    logic [rskc_pkg::DIV_DEN_W-1:0] r_rem;
    logic [rskc_pkg::DIV_DEN_W-1:0] r_den;
    logic [rskc_pkg::DIV_Q_W-1:0]   r_low;
    logic [rskc_pkg::DIV_Q_W-1:0]   r_quot;
    logic [3:0]                     r_cnt;
    logic                           r_done;
    logic [rskc_pkg::DIV_DEN_W:0]   trial;
    logic                           fits;

    always_comb begin
        trial = {r_rem, r_low[rskc_pkg::DIV_Q_W-1]};
        fits  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 4'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 4'd1);
            if (i_req.start) begin
                r_cnt <= 4'(rskc_pkg::DIV_Q_W);
            end else if (r_cnt != 4'd0) begin
                r_cnt <= r_cnt - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= rskc_pkg::DIV_DEN_W'(
                i_req.num[rskc_pkg::DIV_NUM_W-1:rskc_pkg::DIV_Q_W]);
            r_low  <= i_req.num[rskc_pkg::DIV_Q_W-1:0];
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_cnt != 4'd0) begin
            if (fits) begin
                r_rem <= rskc_pkg::DIV_DEN_W'(trial - {1'b0, r_den});
            end else begin
                r_rem <= rskc_pkg::DIV_DEN_W'(trial);
            end
            r_low  <= r_low << 1;
            r_quot <= {r_quot[rskc_pkg::DIV_Q_W-2:0], fits};
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule
